### rtl/core/wepid_pkg.sv
// Shared types, constants and the control-store program of the encoder position PID.
package wepid_pkg;

   // fixed field widths
   localparam int POS_W       = 12;
   localparam int POS_MAX     = 4095;
   localparam int KIND_W      = 2;
   localparam int SPEED_W     = 8;
   localparam int GAIN_W      = 24;
   localparam int ISTEP_W     = 16;
   localparam int LIMIT_W     = 24;
   localparam int OFFSET_W    = 7;
   localparam int MARGIN_W    = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - SPEED_W - 2;

   localparam int ENCODER_RANGE_DEF = 4095;
   localparam int WRAP_JUMP         = 3000;
   localparam int FRAC_W            = 16;
   localparam int ROUND_SHIFT       = 32;
   localparam int DRIVE_POS_LIM     = 127;
   localparam int DRIVE_NEG_LIM     = 128;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TARGET = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D_RATE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_STEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_OFS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN      = 3'd6;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d_rate;
      logic [ISTEP_W-1:0]  integ_step;
      logic [LIMIT_W-1:0]  integral_limit;
      logic [OFFSET_W-1:0] drive_offset;
      logic [MARGIN_W-1:0] target_margin;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:         24'd196608,
      gain_i:         24'd3277,
      gain_d_rate:    24'd131072,
      integ_step:     16'd3277,
      integral_limit: 24'd6553600,
      drive_offset:   7'd55,
      target_margin:  8'd1
   };

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic                      at_target;
      logic                      idle;
   } status_type;

   // control word fields
   typedef enum logic [1:0] {WAY_NONE, WAY_ALWAYS, WAY_IF_JUMP} way_sel_type;
   typedef enum logic [1:0] {MA_ERR, MA_DIFF, MA_INTEG} mul_a_type;
   typedef enum logic [1:0] {MB_ISTEP, MB_GAIN_P, MB_GAIN_D, MB_GAIN_I} mul_b_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD16, ACC_ADD16, ACC_ADD} acc_op_type;
   typedef enum logic [2:0] {J_NEXT, J_KIND, J_GOTO, J_IF_IDLE, J_DONE} jmp_type;

   localparam int PC_W = 4;

   typedef struct packed {
      logic              dispatch;
      way_sel_type       way;
      logic              err_ld;
      logic              mul_en;
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      logic              integ_ld;
      acc_op_type        acc_op;
      logic              rnd_ld;
      logic              out_ld;
      logic              reply;
      jmp_type           jmp;
      logic [PC_W-1:0]   addr;
   } ctrl_type;

   // program addresses
   localparam logic [PC_W-1:0] ADDR_DISPATCH = 4'd0;
   localparam logic [PC_W-1:0] ADDR_WAY_T    = 4'd1;
   localparam logic [PC_W-1:0] ADDR_WAY_S    = 4'd2;
   localparam logic [PC_W-1:0] ADDR_ERR      = 4'd3;
   localparam logic [PC_W-1:0] ADDR_MUL_I    = 4'd4;
   localparam logic [PC_W-1:0] ADDR_INTEG    = 4'd5;
   localparam logic [PC_W-1:0] ADDR_SUM_P    = 4'd6;
   localparam logic [PC_W-1:0] ADDR_SUM_D    = 4'd7;
   localparam logic [PC_W-1:0] ADDR_SUM_I    = 4'd8;
   localparam logic [PC_W-1:0] ADDR_ROUND    = 4'd9;
   localparam logic [PC_W-1:0] ADDR_DRIVE    = 4'd10;
   localparam logic [PC_W-1:0] ADDR_REPLY    = 4'd11;

   function automatic ctrl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_type cw;
      cw = '0;
      unique case (pc)
         ADDR_DISPATCH: begin
            cw.dispatch = 1'b1;
            cw.jmp      = J_KIND;
            cw.addr     = ADDR_REPLY;
         end
         ADDR_WAY_T: begin
            cw.way  = WAY_ALWAYS;
            cw.jmp  = J_GOTO;
            cw.addr = ADDR_ERR;
         end
         ADDR_WAY_S: begin
            cw.way  = WAY_IF_JUMP;
            cw.jmp  = J_IF_IDLE;
            cw.addr = ADDR_REPLY;
         end
         ADDR_ERR: begin
            cw.err_ld = 1'b1;
         end
         ADDR_MUL_I: begin
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_ERR;
            cw.mul_b  = MB_ISTEP;
         end
         ADDR_INTEG: begin
            cw.integ_ld = 1'b1;
            cw.mul_en   = 1'b1;
            cw.mul_a    = MA_ERR;
            cw.mul_b    = MB_GAIN_P;
         end
         ADDR_SUM_P: begin
            cw.acc_op = ACC_LOAD16;
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_DIFF;
            cw.mul_b  = MB_GAIN_D;
         end
         ADDR_SUM_D: begin
            cw.acc_op = ACC_ADD16;
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_INTEG;
            cw.mul_b  = MB_GAIN_I;
         end
         ADDR_SUM_I: begin
            cw.acc_op = ACC_ADD;
         end
         ADDR_ROUND: begin
            cw.rnd_ld = 1'b1;
         end
         ADDR_DRIVE: begin
            cw.out_ld = 1'b1;
         end
         ADDR_REPLY: begin
            cw.reply = 1'b1;
            cw.jmp   = J_DONE;
            cw.addr  = ADDR_DISPATCH;
         end
         default: begin
            cw.jmp  = J_GOTO;
            cw.addr = ADDR_DISPATCH;
         end
      endcase
      return cw;
   endfunction

endpackage

### rtl/core/wepid_datapath.sv
// Datapath of the encoder position PID: controller state, shared multiplier and accumulator.
module wepid_datapath
   import wepid_pkg::*;
#(
   parameter int ENCODER_RANGE = ENCODER_RANGE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  cfg_type           cfg,
   input  logic [KIND_W-1:0] kind,
   input  logic [POS_W-1:0]  value,
   output status_type        status
);

   localparam int ERR_W  = $clog2(ENCODER_RANGE + POS_MAX + 1) + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int INT_W  = LIMIT_W + 1;
   localparam int MA_W   = (DIFF_W > INT_W) ? DIFF_W : INT_W;
   localparam int MB_W   = GAIN_W + 1;
   localparam int PROD_W = MA_W + MB_W;
   localparam int SUM_W  = ERR_W + GAIN_W + FRAC_W + 3;
   localparam int RND_W  = SUM_W - ROUND_SHIFT;
   localparam int WAY_W  = ERR_W + 1;

   localparam logic signed [ERR_W-1:0] RANGE_E = ERR_W'(ENCODER_RANGE);
   localparam logic signed [WAY_W-1:0] RANGE_W = WAY_W'(ENCODER_RANGE);
   localparam logic [SUM_W-1:0] RND_POS = SUM_W'(64'h8000_0000);
   localparam logic [SUM_W-1:0] RND_NEG = SUM_W'(64'h8000_0001);

   // controller state
   logic [POS_W-1:0]          target_ff, pos_ff;
   logic signed [SPEED_W-1:0] drive_ff;
   logic                      down_ff, cross_ff, idle_ff, jump_ff;
   logic signed [INT_W-1:0]   integ_ff;
   logic signed [ERR_W-1:0]   last_ff;

   // working registers
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SUM_W-1:0]   acc_ff;
   logic [RND_W-1:0]          rnd_ff;
   logic                      neg_ff;

   // way selection
   logic signed [WAY_W-1:0] t_w, p_w, fwd_dist, back_dist;
   logic tp_gt, direct, way_down, way_cross, way_en;

   assign t_w   = WAY_W'(target_ff);
   assign p_w   = WAY_W'(pos_ff);
   assign tp_gt = target_ff > pos_ff;

   always_comb begin
      if (tp_gt) begin
         fwd_dist  = t_w - p_w;
         back_dist = p_w + (RANGE_W - t_w);
      end else begin
         fwd_dist  = p_w - t_w;
         back_dist = (t_w + RANGE_W) - p_w;
      end
      direct    = fwd_dist < back_dist;
      way_down  = tp_gt ? !direct : direct;
      way_cross = !direct;
   end

   assign way_en = (ctrl.way == WAY_ALWAYS) || ((ctrl.way == WAY_IF_JUMP) && jump_ff);

   // error and its change since the last step
   logic signed [ERR_W-1:0]  t_e, p_e, base_err, err_next;
   logic signed [DIFF_W-1:0] diff_next;

   assign t_e      = ERR_W'(target_ff);
   assign p_e      = ERR_W'(pos_ff);
   assign base_err = t_e - p_e;

   always_comb begin
      if (cross_ff) begin
         err_next = down_ff ? (base_err - RANGE_E) : (base_err + RANGE_E);
      end else begin
         err_next = base_err;
      end
      diff_next = DIFF_W'(err_next) - DIFF_W'(last_ff);
   end

   // shared multiplier operands
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;

   always_comb begin
      unique case (ctrl.mul_a)
         MA_ERR:   mul_a = MA_W'(err_ff);
         MA_DIFF:  mul_a = MA_W'(diff_ff);
         MA_INTEG: mul_a = MA_W'(integ_ff);
         default:  mul_a = '0;
      endcase
      unique case (ctrl.mul_b)
         MB_ISTEP:  mul_b = MB_W'(cfg.integ_step);
         MB_GAIN_P: mul_b = MB_W'(cfg.gain_p);
         MB_GAIN_D: mul_b = MB_W'(cfg.gain_d_rate);
         MB_GAIN_I: mul_b = MB_W'(cfg.gain_i);
         default:   mul_b = '0;
      endcase
   end

   // integral with symmetric saturation
   logic signed [PROD_W:0]  integ_sum, lim_pos, lim_neg;
   logic signed [INT_W-1:0] integ_next;

   assign integ_sum = (PROD_W+1)'(integ_ff) + (PROD_W+1)'(prod_ff);
   assign lim_pos   = (PROD_W+1)'(cfg.integral_limit);
   assign lim_neg   = -lim_pos;

   always_comb begin
      priority if (integ_sum > lim_pos) begin
         integ_next = INT_W'(lim_pos);
      end else if (integ_sum < lim_neg) begin
         integ_next = INT_W'(lim_neg);
      end else begin
         integ_next = INT_W'(integ_sum);
      end
   end

   // accumulate the three terms
   logic signed [SUM_W-1:0] prod_ext, prod_shift, acc_next;

   assign prod_ext   = SUM_W'(prod_ff);
   assign prod_shift = prod_ext <<< FRAC_W;

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:   acc_next = acc_ff;
         ACC_LOAD16: acc_next = prod_shift;
         ACC_ADD16:  acc_next = acc_ff + prod_shift;
         ACC_ADD:    acc_next = acc_ff + prod_ext;
         default:    acc_next = acc_ff;
      endcase
   end

   // round magnitude, halves away from zero: |x| + half in one add
   logic [SUM_W-1:0] rnd_sum;

   assign rnd_sum = acc_ff[SUM_W-1] ? (~$unsigned(acc_ff) + RND_NEG)
                                    : ($unsigned(acc_ff) + RND_POS);

   // minimum-drive offset and clamp
   logic [RND_W:0]            drive_mag, drive_mag_neg;
   logic                      neg_eff;
   logic signed [SPEED_W-1:0] drive_next;

   assign drive_mag     = (RND_W+1)'(rnd_ff) + (RND_W+1)'(cfg.drive_offset);
   assign drive_mag_neg = (RND_W+1)'(0) - drive_mag;
   assign neg_eff       = neg_ff && (rnd_ff != '0);

   always_comb begin
      if (neg_eff) begin
         drive_next = (drive_mag > (RND_W+1)'(DRIVE_NEG_LIM))
                      ? SPEED_W'(-DRIVE_NEG_LIM) : drive_mag_neg[SPEED_W-1:0];
      end else begin
         drive_next = (drive_mag > (RND_W+1)'(DRIVE_POS_LIM))
                      ? SPEED_W'(DRIVE_POS_LIM) : drive_mag[SPEED_W-1:0];
      end
   end

   // encoder jump on a new sample
   logic [POS_W-1:0] jump_dist;

   assign jump_dist = (value >= pos_ff) ? (value - pos_ff) : (pos_ff - value);

   // circular distance to target
   logic [POS_W-1:0]        near_d;
   logic signed [ERR_W-1:0] near_d_s, near_other, margin_s;
   logic                    near;

   assign near_d     = (pos_ff >= target_ff) ? (pos_ff - target_ff) : (target_ff - pos_ff);
   assign near_d_s   = ERR_W'(near_d);
   assign near_other = RANGE_E - near_d_s;
   assign margin_s   = ERR_W'(cfg.target_margin);
   assign near       = (near_d_s <= margin_s) || (near_other <= margin_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         pos_ff    <= '0;
         drive_ff  <= '0;
         down_ff   <= 1'b0;
         cross_ff  <= 1'b0;
         idle_ff   <= 1'b1;
         jump_ff   <= 1'b0;
         integ_ff  <= '0;
         last_ff   <= '0;
      end else begin
         if (ctrl.dispatch) begin
            unique case (kind)
               KIND_TARGET: begin
                  target_ff <= value;
                  integ_ff  <= '0;
                  last_ff   <= '0;
                  idle_ff   <= 1'b0;
               end
               KIND_SAMPLE: begin
                  pos_ff  <= value;
                  jump_ff <= jump_dist > POS_W'(WRAP_JUMP);
               end
               KIND_STOP: begin
                  drive_ff <= '0;
                  idle_ff  <= 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (way_en) begin
            down_ff  <= way_down;
            cross_ff <= way_cross;
         end
         if (ctrl.integ_ld) begin
            integ_ff <= integ_next;
         end
         if (ctrl.out_ld) begin
            drive_ff <= drive_next;
            last_ff  <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.err_ld) begin
         err_ff  <= err_next;
         diff_ff <= diff_next;
      end
      if (ctrl.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      acc_ff <= acc_next;
      if (ctrl.rnd_ld) begin
         rnd_ff <= rnd_sum[SUM_W-1:ROUND_SHIFT];
         neg_ff <= acc_ff[SUM_W-1];
      end
   end

   assign status.speed     = drive_ff;
   assign status.at_target = near;
   assign status.idle      = idle_ff;

endmodule

### rtl/core/wrapping_encoder_position_pid.sv
// Top level of the encoder position PID: control sequencer, registers and stream ports.
// A target item or an active sample runs the way choice, error, multiply, integrate, sum,
// round and drive steps before its reply; an idle sample goes from the way choice to the
// reply, and a stop or unused kind goes straight to it. Input is taken only while the
// program sits at dispatch, so a new item waits for the last one's reply step, and a
// stalled result holds the program and the input. Synchronous reset loads register defaults.
module wrapping_encoder_position_pid
   import wepid_pkg::*;
#(
   parameter int ENCODER_RANGE = ENCODER_RANGE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [11:0] value
   input  logic [KIND_W-1:0]      req_tuser,   // [1:0] kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] speed, [8] at_target, [9] idle
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:      cfg_ff.gain_p         <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:      cfg_ff.gain_i         <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D_RATE: cfg_ff.gain_d_rate    <= csr_wdata[GAIN_W-1:0];
            CSR_INTEG_STEP:  cfg_ff.integ_step     <= csr_wdata[ISTEP_W-1:0];
            CSR_INTEG_LIMIT: cfg_ff.integral_limit <= csr_wdata[LIMIT_W-1:0];
            CSR_DRIVE_OFS:   cfg_ff.drive_offset   <= csr_wdata[OFFSET_W-1:0];
            CSR_MARGIN:      cfg_ff.target_margin  <= csr_wdata[MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_type        rom_word, ctrl;
   status_type      status;
   logic            step_go, req_fire, out_room;
   logic            rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign rom_word   = ucode_rom(pc_ff);
   assign req_tready = (rom_word.jmp == J_KIND);
   assign req_fire   = req_tvalid && req_tready;
   assign out_room   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      step_go = 1'b1;
      pc_in   = PC_W'(pc_ff + 1'b1);
      unique case (rom_word.jmp)
         J_NEXT: begin
         end
         J_KIND: begin
            step_go = req_fire;
            priority if (!req_fire) begin
               pc_in = pc_ff;
            end else if (req_tuser == KIND_TARGET) begin
               pc_in = ADDR_WAY_T;
            end else if (req_tuser == KIND_SAMPLE) begin
               pc_in = ADDR_WAY_S;
            end else begin
               pc_in = rom_word.addr;
            end
         end
         J_GOTO: begin
            pc_in = rom_word.addr;
         end
         J_IF_IDLE: begin
            if (status.idle) begin
               pc_in = rom_word.addr;
            end
         end
         J_DONE: begin
            // hold until the output register is free
            step_go = out_room;
            pc_in   = out_room ? rom_word.addr : pc_ff;
         end
         default: begin
            pc_in = ADDR_DISPATCH;
         end
      endcase
      ctrl = step_go ? rom_word : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ADDR_DISPATCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

   wepid_datapath #(
      .ENCODER_RANGE(ENCODER_RANGE)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_ff),
      .kind   (req_tuser),
      .value  (req_tdata[POS_W-1:0]),
      .status (status)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.reply) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, status.idle, status.at_target, status.speed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### dv/wepid_status_checker.sv
// Scoreboard for the encoder position PID: tracks register writes, predicts and checks every status item.
`timescale 1ns / 1ps
module wepid_status_checker
   import wepid_pkg::*;
#(
   parameter int ENCODER_RANGE = ENCODER_RANGE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [11:0] value
   input  logic [KIND_W-1:0]      req_tuser,   // [1:0] kind
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] speed, [8] at_target, [9] idle
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatch_count,
   output int unsigned            awaiting
);

   localparam int     REPORT_MAX = 10;
   localparam longint ONE_Q16    = 64'sd1 << FRAC_W;
   localparam longint unsigned HALF_LSB = 64'd1 << (ROUND_SHIFT - 1);

   cfg_type                   cfg;
   logic [POS_W-1:0]          pos_now;
   logic [POS_W-1:0]          pos_prev;
   logic [POS_W-1:0]          aim;
   logic signed [SPEED_W-1:0] drive;
   bit                        way_down;
   bit                        over_wrap;
   bit                        halted;
   longint                    integ;
   longint                    prev_err;
   status_type                status_due[$];
   int unsigned               fails = 0;
   int unsigned               due_count = 0;

   assign mismatch_count = fails;
   assign awaiting       = due_count;

   // shorter way round the circle from pos_now to aim
   function void pick_way();
      longint t, p, r;
      bit     direct;
      t = aim;
      p = pos_now;
      r = ENCODER_RANGE;
      if (t > p) begin
         direct    = (t - p) < (p + (r - t));
         way_down  = !direct;
         over_wrap = !direct;
      end else begin
         direct    = (p - t) < ((t + r) - p);
         way_down  = direct;
         over_wrap = !direct;
      end
   endfunction

   function void pid_update();
      longint t, p, r, e, lim, acc, sum, v;
      longint gp, gi, gd, istep, ofs;
      longint unsigned mag, rnd;
      bit     neg;
      t     = aim;
      p     = pos_now;
      r     = ENCODER_RANGE;
      gp    = cfg.gain_p;
      gi    = cfg.gain_i;
      gd    = cfg.gain_d_rate;
      istep = cfg.integ_step;
      lim   = cfg.integral_limit;
      ofs   = cfg.drive_offset;
      if (over_wrap) e = way_down ? (t - r - p) : (t + r - p);
      else e = t - p;
      acc = integ + e * istep;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integ = acc;
      sum = gp * e * ONE_Q16 + gi * acc + gd * (e - prev_err) * ONE_Q16;
      prev_err = e;
      // round half away from zero on the magnitude
      neg = sum < 0;
      mag = neg ? longint'(-sum) : longint'(sum);
      rnd = (mag + HALF_LSB) >> ROUND_SHIFT;
      v   = neg ? -longint'(rnd) : longint'(rnd);
      if (v < 0) v = v - ofs;
      else v = v + ofs;
      if (v > DRIVE_POS_LIM) v = DRIVE_POS_LIM;
      if (v < -DRIVE_NEG_LIM) v = -DRIVE_NEG_LIM;
      drive = SPEED_W'(v);
   endfunction

   function bit near_aim();
      longint p, t, d, other;
      p = pos_now;
      t = aim;
      d = p - t;
      if (d < 0) d = -d;
      other = longint'(ENCODER_RANGE) - d;
      return ((d < other) ? d : other) <= longint'(cfg.target_margin);
   endfunction

   function status_type take_item(input logic [KIND_W-1:0] kind,
                                  input logic [POS_W-1:0] val);
      longint     a, b, jump;
      status_type s;
      case (kind)
         KIND_TARGET: begin
            aim      = val;
            integ    = 0;
            prev_err = 0;
            halted   = 1'b0;
            pick_way();
            pid_update();
         end
         KIND_SAMPLE: begin
            pos_prev = pos_now;
            pos_now  = val;
            a        = pos_now;
            b        = pos_prev;
            jump     = (a > b) ? (a - b) : (b - a);
            if (jump > WRAP_JUMP) pick_way();
            if (!halted) pid_update();
         end
         KIND_STOP: begin
            drive  = '0;
            halted = 1'b1;
         end
         default: ;
      endcase
      s.speed     = drive;
      s.at_target = near_aim();
      s.idle      = halted;
      return s;
   endfunction

   always @(posedge clock) begin : watch
      status_type want;
      status_type got;
      if (reset) begin
         cfg       = CFG_RESET;
         pos_now   = '0;
         pos_prev  = '0;
         aim       = '0;
         drive     = '0;
         way_down  = 1'b0;
         over_wrap = 1'b0;
         halted    = 1'b1;
         integ     = 0;
         prev_err  = 0;
         status_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_P:      cfg.gain_p         = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I:      cfg.gain_i         = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D_RATE: cfg.gain_d_rate    = csr_wdata[GAIN_W-1:0];
               CSR_INTEG_STEP:  cfg.integ_step     = csr_wdata[ISTEP_W-1:0];
               CSR_INTEG_LIMIT: cfg.integral_limit = csr_wdata[LIMIT_W-1:0];
               CSR_DRIVE_OFS:   cfg.drive_offset   = csr_wdata[OFFSET_W-1:0];
               CSR_MARGIN:      cfg.target_margin  = csr_wdata[MARGIN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            status_due.push_back(take_item(req_tuser, req_tdata[POS_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got.speed     = rsp_tdata[SPEED_W-1:0];
            got.at_target = rsp_tdata[SPEED_W];
            got.idle      = rsp_tdata[SPEED_W+1];
            if (status_due.size() == 0) begin
               if (fails < REPORT_MAX)
                  $display("%0t: status item with none expected: speed %0d at_target %0b idle %0b",
                           $time, got.speed, got.at_target, got.idle);
               fails++;
            end else begin
               want = status_due.pop_front();
               if (got !== want) begin
                  if (fails < REPORT_MAX) begin
                     $write("%0t: status mismatch: speed exp %0d got %0d, ",
                            $time, want.speed, got.speed);
                     $display("at_target exp %0b got %0b, idle exp %0b got %0b",
                              want.at_target, got.at_target, want.idle, got.idle);
                  end
                  fails++;
               end
            end
         end
      end
      due_count = status_due.size();
   end

endmodule

### dv/wrapping_encoder_position_pid_tb.sv
// Testbench top of the encoder position PID: clock, reset, item and register stimulus, verdict.
`timescale 1ns / 1ps
module wrapping_encoder_position_pid_tb;
   import wepid_pkg::*;

   localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 3'd7;
   localparam int                     HOLD_CYCLES = 400;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            mismatch_count;
   int unsigned            awaiting;

   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   bit                     long_hold = 1'b0;
   logic [POS_W-1:0]       walk_pos = '0;
   logic [POS_W-1:0]       aim_pos = '0;

   wrapping_encoder_position_pid i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wepid_status_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stalls, plus one long hold-off counted here
   initial begin : rsp_side
      int unsigned hold_count;
      int          stall_now;
      bit          hold_seen;
      hold_count = 0;
      hold_seen  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         stall_now = stall_pct;
         if (long_hold && !hold_seen) begin
            hold_seen  = 1'b1;
            hold_count = HOLD_CYCLES;
         end
         @(negedge clock);
         if (hold_count > 0) begin
            rsp_tready <= 1'b0;
            hold_count--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_now);
         end
      end
   end

   // leaves req_tvalid high; the caller lowers it when no item follows
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (kind == KIND_SAMPLE) walk_pos = value;
      if (kind == KIND_TARGET) aim_pos = value;
   endtask

   task automatic send_random();
      int               roll;
      logic [POS_W-1:0] v;
      roll = $urandom_range(99);
      if (roll < 12) begin
         v = $urandom_range(1) ? POS_W'($urandom) : POS_W'(walk_pos + $urandom_range(60) - 30);
         send_item(KIND_TARGET, v);
      end else if (roll < 85) begin
         // mostly a slow walk that wraps past the ends now and then
         case ($urandom_range(9))
            0: v = POS_W'($urandom);
            1: v = POS_W'(aim_pos + $urandom_range(6) - 3);
            2: v = $urandom_range(1) ? '0 : POS_W'(POS_MAX);
            default: v = POS_W'(walk_pos + $urandom_range(400) - 200);
         endcase
         send_item(KIND_SAMPLE, v);
      end else if (roll < 94) begin
         send_item(KIND_STOP, POS_W'($urandom));
      end else begin
         send_item(KIND_UNUSED, POS_W'($urandom));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int n, input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (n) send_random();
      drain();
   endtask

   task automatic put_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= d;
      @(negedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      put_csr(CSR_GAIN_P, c.gain_p);
      put_csr(CSR_GAIN_I, c.gain_i);
      put_csr(CSR_GAIN_D_RATE, c.gain_d_rate);
      put_csr(CSR_INTEG_STEP, c.integ_step);
      put_csr(CSR_INTEG_LIMIT, c.integral_limit);
      put_csr(CSR_DRIVE_OFS, c.drive_offset);
      put_csr(CSR_MARGIN, c.target_margin);
      // no register there: must change nothing
      put_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.gain_p         = GAIN_W'($urandom_range(1 << 15));
      c.gain_i         = GAIN_W'($urandom_range(1 << 20));
      c.gain_d_rate    = GAIN_W'($urandom_range(1 << 15));
      c.integ_step     = ISTEP_W'($urandom);
      c.integral_limit = LIMIT_W'($urandom);
      c.drive_offset   = OFFSET_W'($urandom_range(40));
      c.target_margin  = MARGIN_W'($urandom);
      return c;
   endfunction

   initial begin : stimulus
      cfg_type all_ones;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_TARGET;
      csr_we     <= 1'b0;
      csr_index  <= CSR_GAIN_P;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      all_ones = '1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, register defaults, no idling
      send_item(KIND_SAMPLE, 12'd0);      // sample while idle
      send_item(KIND_STOP, 12'd4095);     // value on a stop
      send_item(KIND_UNUSED, 12'hABC);
      send_item(KIND_TARGET, 12'd4095);
      send_item(KIND_SAMPLE, 12'd4095);
      send_item(KIND_SAMPLE, 12'd0);
      send_item(KIND_SAMPLE, 12'd3000);   // jump right at the wrap threshold
      send_item(KIND_SAMPLE, 12'd0);
      send_item(KIND_SAMPLE, 12'd3001);   // just past it
      send_item(KIND_TARGET, 12'd0);
      send_item(KIND_SAMPLE, 12'd2048);
      send_item(KIND_SAMPLE, 12'd2047);
      send_item(KIND_UNUSED, 12'h555);    // unused kind while running
      send_item(KIND_TARGET, 12'd100);
      send_item(KIND_SAMPLE, 12'd4000);
      send_item(KIND_SAMPLE, 12'd50);
      send_item(KIND_STOP, 12'd0);
      send_item(KIND_SAMPLE, 12'd3100);
      send_item(KIND_SAMPLE, 12'd10);
      send_item(KIND_TARGET, 12'd2000);
      send_item(KIND_SAMPLE, 12'd2001);
      send_item(KIND_SAMPLE, 12'd1999);
      send_item(KIND_SAMPLE, 12'd2000);
      send_item(KIND_TARGET, 12'd1);
      send_item(KIND_SAMPLE, 12'd4095);
      drain();

      run_phase(60, 0, 0);
      load_config(all_ones);
      run_phase(50, 75, 0);
      load_config('0);
      run_phase(40, 0, 75);
      load_config(random_config());
      run_phase(80, 30, 30);
      // sender keeps offering while the result side holds off
      load_config(random_config());
      long_hold = 1'b1;
      run_phase(60, 0, 0);
      load_config(random_config());
      run_phase(60, 30, 30);
      load_config(CFG_RESET);
      run_phase(50, 75, 75);

      repeat (16) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/wepid_pkg.sv
rtl/core/wepid_datapath.sv
rtl/core/wrapping_encoder_position_pid.sv
dv/wepid_status_checker.sv
dv/wrapping_encoder_position_pid_tb.sv
